>>> rtl/lfu_pkg.sv
// Shared types and constants for the LFU key-value store.
// Field widths, request codes and the capacity register's reset value.
// No dependencies.
`default_nettype none

package lfu_pkg;

  // Widths of the payload fields and of the per-entry use count.
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned USE_W = 32;
  localparam int unsigned CAP_W = 5;

  // Saturation value of a use count.
  localparam logic [USE_W-1:0] USE_MAX = {USE_W{1'b1}};

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

  // Request kinds.
  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } mode_e;

endpackage

`default_nettype wire

>>> rtl/lfu_entry_ram.sv
// Entry store of the LFU block: one write port and one read port.
// Read data is registered and appears in the cycle after the read. Depends on nothing.
`default_nettype none

module lfu_entry_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 100
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/lfu_ctrl.sv
// Request sequencer of the LFU block: scan pass, decision and update pass.
// Uses lfu_pkg; drives the read and write ports of lfu_entry_ram.
`default_nettype none

module lfu_ctrl #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned IDX_W       = 4,
  parameter int unsigned CNT_W       = 5,
  parameter int unsigned ENT_W       = 100
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        mode_i,
  input  wire logic [lfu_pkg::KEY_W-1:0]   key_i,
  input  wire logic [lfu_pkg::VAL_W-1:0]   value_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [lfu_pkg::CAP_W-1:0]   cfg_wdata_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic [lfu_pkg::VAL_W-1:0]        read_value_o,
  output logic                             evicted_o,
  output logic [lfu_pkg::KEY_W-1:0]        evicted_key_o,
  output logic                             ram_rd_en_o,
  output logic [IDX_W-1:0]                 ram_rd_addr_o,
  input  wire logic [ENT_W-1:0]            ram_rd_data_i,
  output logic                             ram_wr_en_o,
  output logic [IDX_W-1:0]                 ram_wr_addr_o,
  output logic [ENT_W-1:0]                 ram_wr_data_o
);

  import lfu_pkg::*;

  // Entry word layout: {key, value, use count, recency rank}.
  localparam int unsigned RANK_W  = IDX_W;
  localparam int unsigned CNT_LSB = RANK_W;
  localparam int unsigned VAL_LSB = CNT_LSB + USE_W;
  localparam int unsigned KEY_LSB = VAL_LSB + VAL_W;
  localparam int unsigned CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [CNT_W-1:0] PTR_END  = CNT_W'(MAX_ENTRIES);
  localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_ENTRIES);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       ptr_q, ptr_d;
  logic                   pipe_vld_q;
  logic [IDX_W-1:0]       pipe_idx_q;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]       occ_q, occ_d;
  logic [CAP_W-1:0]       cap_q;

  // Request held for the whole transfer.
  logic                   req_put_q;
  logic [KEY_W-1:0]       req_key_q;
  logic [VAL_W-1:0]       req_val_q;

  // Scan findings.
  logic                   hit_found_q;
  logic [IDX_W-1:0]       hit_idx_q;
  logic [VAL_W-1:0]       hit_val_q;
  logic [USE_W-1:0]       hit_cnt_q;
  logic [RANK_W-1:0]      hit_rank_q;
  logic                   free_found_q;
  logic [IDX_W-1:0]       free_idx_q;
  logic                   vic_found_q;
  logic [IDX_W-1:0]       vic_idx_q;
  logic [USE_W-1:0]       vic_cnt_q;
  logic [RANK_W-1:0]      vic_rank_q;
  logic [KEY_W-1:0]       vic_key_q;

  // Decision for the update pass.
  logic [IDX_W-1:0]       tgt_idx_q, tgt_idx_d;
  logic                   gap_en_q, gap_en_d;
  logic [RANK_W-1:0]      gap_rank_q, gap_rank_d;
  logic [ENT_W-1:0]       new_word_q, new_word_d;

  // Result registers.
  logic                   res_hit_q, res_hit_d;
  logic [VAL_W-1:0]       res_rd_q, res_rd_d;
  logic                   res_ev_q, res_ev_d;
  logic [KEY_W-1:0]       res_evk_q, res_evk_d;

  // Fields of the entry word just read.
  logic [KEY_W-1:0]       rd_key;
  logic [VAL_W-1:0]       rd_val;
  logic [USE_W-1:0]       rd_cnt;
  logic [RANK_W-1:0]      rd_rank;
  logic                   rd_valid;
  logic                   pipe_last;
  logic                   accept;
  logic                   walking;

  // Decision terms.
  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       cap_eff;
  logic                   dec_hit;
  logic                   dec_ins;
  logic                   dec_ev;
  logic [USE_W-1:0]       new_cnt;
  logic [VAL_W-1:0]       new_val;
  logic [RANK_W-1:0]      new_rank;
  logic                   rank_dec;

  assign rd_key   = ram_rd_data_i[KEY_LSB +: KEY_W];
  assign rd_val   = ram_rd_data_i[VAL_LSB +: VAL_W];
  assign rd_cnt   = ram_rd_data_i[CNT_LSB +: USE_W];
  assign rd_rank  = ram_rd_data_i[0 +: RANK_W];
  assign rd_valid = valid_q[pipe_idx_q];

  assign pipe_last = pipe_vld_q && (pipe_idx_q == LAST_IDX);
  assign accept    = start && (state_q == ST_IDLE);
  assign busy      = (state_q != ST_IDLE);

  // Both passes walk every entry, one read issued per cycle.
  assign walking       = (state_q == ST_SCAN) || (state_q == ST_UPDATE);
  assign ram_rd_en_o   = walking && (ptr_q != PTR_END);
  assign ram_rd_addr_o = ptr_q[IDX_W-1:0];

  // Effective capacity, clipped to the built store size.
  assign cap_ext = CMP_W'(cap_q);
  assign cap_eff = (cap_ext > MAX_CMP) ? MAX_CMP : cap_ext;

  // What the request does, from the scan findings.
  always_comb begin
    dec_hit = hit_found_q;
    dec_ins = !hit_found_q && req_put_q && (cap_eff != '0);
    dec_ev  = dec_ins && vic_found_q && (CMP_W'(occ_q) >= cap_eff);

    if (dec_hit) begin
      tgt_idx_d = hit_idx_q;
    end else if (dec_ev) begin
      tgt_idx_d = (free_found_q && (free_idx_q < vic_idx_q)) ? free_idx_q : vic_idx_q;
    end else begin
      tgt_idx_d = free_idx_q;
    end

    gap_en_d   = dec_hit || dec_ev;
    gap_rank_d = dec_hit ? hit_rank_q : vic_rank_q;

    if (dec_hit) begin
      new_cnt = (hit_cnt_q == USE_MAX) ? hit_cnt_q : hit_cnt_q + USE_W'(1);
      new_val = req_put_q ? req_val_q : hit_val_q;
    end else begin
      new_cnt = USE_W'(1);
      new_val = req_val_q;
    end
    new_rank   = (dec_hit || dec_ev) ? RANK_W'(occ_q - CNT_W'(1)) : RANK_W'(occ_q);
    new_word_d = {req_key_q, new_val, new_cnt, new_rank};

    res_hit_d = dec_hit;
    res_rd_d  = (dec_hit && (req_put_q != MODE_PUT)) ? hit_val_q : '0;
    res_ev_d  = dec_ev;
    res_evk_d = dec_ev ? vic_key_q : '0;
  end

  // Occupancy and valid bits change once, when the decision is taken.
  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    if ((state_q == ST_DECIDE) && dec_ins) begin
      if (dec_ev) begin
        valid_d[vic_idx_q] = 1'b0;
      end else begin
        occ_d = occ_q + CNT_W'(1);
      end
      valid_d[tgt_idx_d] = 1'b1;
    end
  end

  // Update pass: rewrite the target entry and close the recency gap.
  assign rank_dec      = gap_en_q && rd_valid && (rd_rank > gap_rank_q);
  assign ram_wr_en_o   = (state_q == ST_UPDATE) && pipe_vld_q;
  assign ram_wr_addr_o = pipe_idx_q;
  always_comb begin
    if (pipe_idx_q == tgt_idx_q) begin
      ram_wr_data_o = new_word_q;
    end else if (rank_dec) begin
      ram_wr_data_o = {ram_rd_data_i[ENT_W-1:RANK_W], rd_rank - RANK_W'(1)};
    end else begin
      ram_wr_data_o = ram_rd_data_i;
    end
  end

  // Next state and read pointer.
  always_comb begin
    state_d = state_q;
    ptr_d   = ram_rd_en_o ? ptr_q + CNT_W'(1) : ptr_q;
    unique case (state_q)
      ST_IDLE: begin
        ptr_d = '0;
        if (start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pipe_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ptr_d   = '0;
        state_d = (dec_hit || dec_ins) ? ST_UPDATE : ST_DONE;
      end
      ST_UPDATE: begin
        if (pipe_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ptr_q      <= '0;
      pipe_vld_q <= 1'b0;
      valid_q    <= '0;
      occ_q      <= '0;
      cap_q      <= CAP_RST;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      pipe_vld_q <= ram_rd_en_o;
      valid_q    <= valid_d;
      occ_q      <= occ_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Request capture and scan bookkeeping.
  always_ff @(posedge clk_i) begin
    pipe_idx_q <= ram_rd_addr_o;
    if (accept) begin
      req_put_q    <= mode_i;
      req_key_q    <= key_i;
      req_val_q    <= value_i;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      vic_found_q  <= 1'b0;
    end else if ((state_q == ST_SCAN) && pipe_vld_q) begin
      if (rd_valid && (rd_key == req_key_q)) begin
        hit_found_q <= 1'b1;
        hit_idx_q   <= pipe_idx_q;
        hit_val_q   <= rd_val;
        hit_cnt_q   <= rd_cnt;
        hit_rank_q  <= rd_rank;
      end
      if (!rd_valid && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= pipe_idx_q;
      end
      // Lowest count wins; on equal counts the least recent one.
      if (rd_valid && (!vic_found_q || (rd_cnt < vic_cnt_q) ||
                       ((rd_cnt == vic_cnt_q) && (rd_rank < vic_rank_q)))) begin
        vic_found_q <= 1'b1;
        vic_idx_q   <= pipe_idx_q;
        vic_cnt_q   <= rd_cnt;
        vic_rank_q  <= rd_rank;
        vic_key_q   <= rd_key;
      end
    end
  end

  // Decision and result registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECIDE) begin
      tgt_idx_q  <= tgt_idx_d;
      gap_en_q   <= gap_en_d;
      gap_rank_q <= gap_rank_d;
      new_word_q <= new_word_d;
      res_hit_q  <= res_hit_d;
      res_rd_q   <= res_rd_d;
      res_ev_q   <= res_ev_d;
      res_evk_q  <= res_evk_d;
    end
  end

  assign done_o        = (state_q == ST_DONE);
  assign hit_o         = res_hit_q;
  assign read_value_o  = res_rd_q;
  assign evicted_o     = res_ev_q;
  assign evicted_key_o = res_evk_q;

endmodule

`default_nettype wire

>>> rtl/lfu_cache_replacement_core.sv
// Top level of the LFU key-value store.
// Uses lfu_pkg, lfu_entry_ram and lfu_ctrl.
//
// A request (get or put of a key) is taken when start is high and busy is
// low; its result appears for exactly one cycle with done_o high and must be
// captured then, as the block cannot be held off. Each request walks the
// entry memory through its single read port, one entry per cycle: a scan
// pass finds the key, the first free slot and the eviction victim, and, on a
// hit or an insert, an update pass rewrites the touched entry and shifts
// recency ranks. A get miss, or a put that stores nothing because capacity
// is zero, skips the update pass. The valid bits live in flip-flops and
// clear at reset, so no clearing pass is needed. Capacity must be written
// only while busy is low; the block itself does not enforce this.
`default_nettype none

module lfu_cache_replacement_core #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        mode_i,
  input  wire logic signed [lfu_pkg::KEY_W-1:0] key_i,
  input  wire logic signed [lfu_pkg::VAL_W-1:0] value_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [lfu_pkg::CAP_W-1:0]   cfg_wdata_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic signed [lfu_pkg::VAL_W-1:0] read_value_o,
  output logic                             evicted_o,
  output logic signed [lfu_pkg::KEY_W-1:0] evicted_key_o
);

  import lfu_pkg::*;

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ENT_W = KEY_W + VAL_W + USE_W + IDX_W;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [VAL_W-1:0] read_value;
  logic [KEY_W-1:0] evicted_key;

  // Entry memory: key, value, use count and recency rank per slot.
  lfu_entry_ram #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (IDX_W),
    .DATA_W (ENT_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Request sequencer.
  lfu_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W),
    .ENT_W       (ENT_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .read_value_o  (read_value),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key),
    .ram_rd_en_o   (rd_en),
    .ram_rd_addr_o (rd_addr),
    .ram_rd_data_i (rd_data),
    .ram_wr_en_o   (wr_en),
    .ram_wr_addr_o (wr_addr),
    .ram_wr_data_o (wr_data)
  );

  assign read_value_o  = $signed(read_value);
  assign evicted_key_o = $signed(evicted_key);

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the LFU key-value store (lfu_cache_replacement_core).
// Uses lfu_pkg for widths and request codes; needs no other files beside the RTL.
// A directed table and then random phases at several capacities, checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import lfu_pkg::*;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned RAND_ITEMS  = 1900;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES = 2 * ENTRIES + 8;
  localparam int unsigned PRINT_LIMIT = 100;

  // One result transfer as the block presents it.
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] rd_val;
    logic             evd;
    logic [KEY_W-1:0] evd_key;
  } lfu_rsp_t;

  typedef enum logic {
    ROW_REQ = 1'b0,
    ROW_CAP = 1'b1
  } row_kind_e;

  // A row of the directed table; fixed rows carry a hand-written result.
  typedef struct {
    row_kind_e        kind;
    mode_e            mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    bit               fixed;
    lfu_rsp_t         rsp;
  } dir_row_t;

  localparam lfu_rsp_t NO_RSP = '0;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    start       = 1'b0;
  logic                    mode_i      = 1'b0;
  logic signed [KEY_W-1:0] key_i       = '0;
  logic signed [VAL_W-1:0] value_i     = '0;
  logic                    cfg_we_i    = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata_i = '0;
  logic                    busy;
  logic                    done_o;
  logic                    hit_o;
  logic signed [VAL_W-1:0] read_value_o;
  logic                    evicted_o;
  logic signed [KEY_W-1:0] evicted_key_o;

  // Predicted store contents and capacity setting.
  logic             ent_vld  [ENTRIES];
  logic [KEY_W-1:0] ent_key  [ENTRIES];
  logic [VAL_W-1:0] ent_val  [ENTRIES];
  logic [USE_W-1:0] ent_use  [ENTRIES];
  int unsigned      ent_rank [ENTRIES];
  int unsigned      ent_occ;
  logic [CAP_W-1:0] cap_reg;

  lfu_rsp_t    pending_rsp_q[$];
  logic [31:0] key_pool[$];
  int unsigned err_cnt   = 0;
  int unsigned stall_cnt = 0;

  // Directed requests: field extremes, hits and misses, value updates,
  // capacity lowered below occupancy, capacity zero and capacity above the store size.
  dir_row_t dir_tab [24] = '{
    '{ROW_REQ, MODE_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, NO_RSP},
    '{ROW_REQ, MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, NO_RSP},
    '{ROW_REQ, MODE_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
      {1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
    '{ROW_REQ, MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, NO_RSP},
    '{ROW_REQ, MODE_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, NO_RSP},
    '{ROW_REQ, MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      {1'b1, 32'h0, 1'b0, 32'h0}},
    '{ROW_REQ, MODE_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      {1'b1, 32'h0, 1'b0, 32'h0}},
    '{ROW_REQ, MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
      {1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    '{ROW_REQ, MODE_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, NO_RSP},
    '{ROW_CAP, MODE_GET, 32'h0000_0000, 32'h0000_0002, 1'b0, NO_RSP},
    '{ROW_REQ, MODE_PUT, 32'h0000_0001, 32'h0000_0001, 1'b0, NO_RSP},
    '{ROW_REQ, MODE_PUT, 32'h0000_0002, 32'h0000_0002, 1'b0, NO_RSP},
    '{ROW_REQ, MODE_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, NO_RSP},
    '{ROW_CAP, MODE_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_RSP},
    '{ROW_REQ, MODE_PUT, 32'h0000_0003, 32'h1234_5678, 1'b1, NO_RSP},
    '{ROW_REQ, MODE_PUT, 32'h0000_0002, 32'h5555_5555, 1'b0, NO_RSP},
    '{ROW_REQ, MODE_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, NO_RSP},
    '{ROW_CAP, MODE_GET, 32'h0000_0000, 32'h0000_001F, 1'b0, NO_RSP},
    '{ROW_REQ, MODE_PUT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, NO_RSP},
    '{ROW_REQ, MODE_GET, 32'h5555_5555, 32'h0000_0000, 1'b1,
      {1'b1, 32'hAAAA_AAAA, 1'b0, 32'h0}},
    '{ROW_CAP, MODE_GET, 32'h0000_0000, 32'h0000_0001, 1'b0, NO_RSP},
    '{ROW_REQ, MODE_PUT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, NO_RSP},
    '{ROW_REQ, MODE_GET, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, NO_RSP},
    '{ROW_CAP, MODE_GET, 32'h0000_0000, 32'h0000_0010, 1'b0, NO_RSP}
  };

  lfu_cache_replacement_core #(
    .MAX_ENTRIES (ENTRIES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

  always #5 clk_i = ~clk_i;

  // Every valid entry more recent than the given rank moves one step down.
  function automatic void close_rank_gap(int unsigned r);
    for (int i = 0; i < ENTRIES; i++) begin
      if (ent_vld[i] && ent_rank[i] > r) ent_rank[i]--;
    end
  endfunction

  // Applies one request to the predicted store and returns its result.
  // Saturation of the use count needs 2**32-1 touches and is out of reach here.
  function automatic lfu_rsp_t lfu_access(mode_e md, logic [KEY_W-1:0] k,
                                          logic [VAL_W-1:0] v);
    lfu_rsp_t    r;
    int          slot;
    int          victim;
    int unsigned lim;
    r      = '0;
    slot   = -1;
    victim = -1;
    lim    = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (ent_vld[i] && ent_key[i] == k) slot = i;
    end
    if (slot >= 0) begin
      // Hit: bump the count, make it the most recent, then read or overwrite.
      r.hit = 1'b1;
      if (ent_use[slot] != USE_MAX) ent_use[slot]++;
      close_rank_gap(ent_rank[slot]);
      ent_rank[slot] = ent_occ - 1;
      if (md == MODE_PUT) ent_val[slot] = v;
      else r.rd_val = ent_val[slot];
    end else if (md == MODE_PUT && lim != 0) begin
      // Full: drop the least-used entry, the least recent one on a tie.
      if (ent_occ >= lim) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (ent_vld[i] && (victim < 0 || ent_use[i] < ent_use[victim] ||
              (ent_use[i] == ent_use[victim] && ent_rank[i] < ent_rank[victim])))
            victim = i;
        end
        if (victim >= 0) begin
          r.evd           = 1'b1;
          r.evd_key       = ent_key[victim];
          ent_vld[victim] = 1'b0;
          close_rank_gap(ent_rank[victim]);
          ent_occ--;
        end
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (!ent_vld[i]) slot = i;
      end
      if (slot >= 0) begin
        ent_vld[slot]  = 1'b1;
        ent_key[slot]  = k;
        ent_val[slot]  = v;
        ent_use[slot]  = 1;
        ent_rank[slot] = ent_occ;
        ent_occ++;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_cnt < PRINT_LIMIT)
      $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    err_cnt++;
  endtask

  // Holds a request on the inputs until the block takes it, then records its result.
  task automatic send_req(mode_e md, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                          bit fixed, lfu_rsp_t typed);
    lfu_rsp_t r;
    start   <= 1'b1;
    mode_i  <= md;
    key_i   <= k;
    value_i <= v;
    do @(posedge clk_i); while (busy !== 1'b0);
    r = lfu_access(md, k, v);
    pending_rsp_q.push_back(fixed ? typed : r);
  endtask

  task automatic idle_cycles(int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Capacity is only written once the block has delivered everything and gone idle.
  task automatic set_capacity(logic [CAP_W-1:0] c);
    start <= 1'b0;
    do @(negedge clk_i); while (pending_rsp_q.size() != 0 || busy !== 1'b0);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg   = c;
  endtask

  // Result monitor: every transfer on the result ports meets the oldest expectation.
  always @(posedge clk_i) begin
    lfu_rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("result with no request outstanding, read_value",
                        read_value_o, '0);
      end else begin
        want = pending_rsp_q.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", 32'(hit_o), 32'(want.hit));
        if (read_value_o !== want.rd_val)
          report_mismatch("read_value", read_value_o, want.rd_val);
        if (evicted_o !== want.evd)
          report_mismatch("evicted", 32'(evicted_o), 32'(want.evd));
        if (evicted_key_o !== want.evd_key)
          report_mismatch("evicted_key", evicted_key_o, want.evd_key);
      end
    end
  end

  // Watchdog: too long without a request or a result transfer ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || done_o === 1'b1) begin
      stall_cnt <= 0;
    end else if (stall_cnt == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Stimulus: reset, directed table, then random phases at changing capacities.
  initial begin
    int unsigned      phase;
    int unsigned      sent;
    int unsigned      n_items;
    int unsigned      lim;
    logic [CAP_W-1:0] cap;
    logic [KEY_W-1:0] k;
    mode_e            md;
    for (int i = 0; i < ENTRIES; i++) ent_vld[i] = 1'b0;
    ent_occ = 0;
    cap_reg = CAP_RST;
    phase   = 0;
    sent    = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CAP) begin
        set_capacity(dir_tab[i].val[CAP_W-1:0]);
      end else begin
        if ($urandom_range(0, 99) < 32) idle_cycles($urandom_range(1, 40));
        send_req(dir_tab[i].mode, dir_tab[i].key, dir_tab[i].val,
                 dir_tab[i].fixed, dir_tab[i].rsp);
      end
    end

    // Each phase uses a small pool of keys sized to the capacity so that hits,
    // updates and evictions are common; a few fully random keys act as noise.
    while (sent < RAND_ITEMS) begin
      case (phase)
        0: begin
          cap = 5'd16;
        end
        1: begin
          cap = 5'd1;
        end
        2: begin
          cap = 5'd0;
        end
        3: begin
          cap = 5'd31;
        end
        4: begin
          cap = 5'd2;
        end
        5: begin
          cap = 5'd16;
        end
        default: begin
          cap = CAP_W'($urandom_range(0, 31));
        end
      endcase
      set_capacity(cap);
      lim = (cap > ENTRIES) ? ENTRIES : cap;
      key_pool.delete();
      repeat (lim + $urandom_range(1, 6)) key_pool.push_back($urandom);
      n_items = $urandom_range(100, 200);
      repeat (n_items) begin
        // Phase 5 runs back to back with no gaps at all.
        if (phase != 5 && $urandom_range(0, 99) < 32) idle_cycles($urandom_range(1, 40));
        md = $urandom_range(0, 1) ? MODE_PUT : MODE_GET;
        if ($urandom_range(0, 15) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        send_req(md, k, $urandom, 1'b0, NO_RSP);
        sent++;
      end
      phase++;
    end

    // Drain, then give the block time to show any stray result.
    start <= 1'b0;
    do @(negedge clk_i); while (pending_rsp_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_rsp_q.size() != 0)
      report_mismatch("results never delivered", pending_rsp_q.size(), '0);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lfu_pkg.sv
rtl/lfu_entry_ram.sv
rtl/lfu_ctrl.sv
rtl/lfu_cache_replacement_core.sv
verif/tb.sv
